// ----- src/dltq_pkg.sv -----
// Shared types and constants for the delta-list timer queue.
package dltq_pkg;

  localparam int MODE_W       = 2;
  localparam int SLOT_IN_W    = 4;
  localparam int PERIOD_W     = 24;
  localparam int ELAPSED_W    = 16;
  localparam int FT_W         = 24;
  localparam int RESULT_CAP   = 16;
  localparam int RES_W        = $clog2(RESULT_CAP + 1);

  localparam int IN_SLOT_LSB     = 0;
  localparam int IN_PERIOD_LSB   = IN_SLOT_LSB + SLOT_IN_W;
  localparam int IN_PERIODIC_LSB = IN_PERIOD_LSB + PERIOD_W;
  localparam int IN_ELAPSED_LSB  = IN_PERIODIC_LSB + 1;
  localparam int IN_USED_W       = IN_ELAPSED_LSB + ELAPSED_W;
  localparam int IN_TDATA_W      = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_USED_W      = SLOT_IN_W + FT_W;
  localparam int OUT_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_TICK   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_COMPACT,
    ST_INSERT,
    ST_POP,
    ST_REARM,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_MARK,
    CELL_COMPACT,
    CELL_POP,
    CELL_SUB,
    CELL_INSERT
  } cell_op_e;

  typedef enum logic [1:0] {
    FB_HOLD,
    FB_CLEAR,
    FB_PUSH,
    FB_ROTATE
  } fb_op_e;

  typedef struct packed {
    logic lt;
    logic shift;
    logic hole;
  } cell_link_t;

endpackage

// ----- src/dltq_cell.sv -----
// One queue position of the delta-list timer row: entry storage and neighbor moves.
module dltq_cell #(
  parameter int SLOT_W = 4,
  parameter int TIME_W = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dltq_pkg::cell_op_e   op_i,
  input  dltq_pkg::cell_link_t prev_link_i,
  output dltq_pkg::cell_link_t link_o,
  input  logic                 prev_valid_i,
  input  logic [SLOT_W-1:0]    prev_slot_i,
  input  logic [TIME_W-1:0]    prev_time_i,
  input  logic [TIME_W-1:0]    prev_reload_i,
  input  logic                 prev_periodic_i,
  input  logic                 next_valid_i,
  input  logic [SLOT_W-1:0]    next_slot_i,
  input  logic [TIME_W-1:0]    next_time_i,
  input  logic [TIME_W-1:0]    next_reload_i,
  input  logic                 next_periodic_i,
  input  logic [SLOT_W-1:0]    key_slot_i,
  input  logic [TIME_W-1:0]    key_time_i,
  input  logic [TIME_W-1:0]    key_reload_i,
  input  logic                 key_periodic_i,
  input  logic [TIME_W-1:0]    sub_i,
  output logic                 valid_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic [TIME_W-1:0]    time_o,
  output logic [TIME_W-1:0]    reload_o,
  output logic                 periodic_o
);
  import dltq_pkg::*;

  logic              valid_q, valid_d;
  logic              hole_q, hole_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [TIME_W-1:0] reload_q, reload_d;
  logic              periodic_q, periodic_d;
  logic              lt, eq, shift;

  // The stored times are remaining times to expiry and kept in nondecreasing order along the row.
  assign lt    = valid_q && (time_q < key_time_i);
  assign eq    = valid_q && (time_q == key_time_i);
  assign shift = !prev_link_i.lt || (!lt && !eq);

  assign link_o = '{lt: lt, shift: shift, hole: hole_q};

  always_comb begin
    valid_d    = valid_q;
    hole_d     = hole_q;
    slot_d     = slot_q;
    time_d     = time_q;
    reload_d   = reload_q;
    periodic_d = periodic_q;
    case (op_i)
      CELL_MARK: begin
        hole_d = valid_q && (slot_q == key_slot_i);
      end
      CELL_COMPACT: begin
        hole_d = prev_link_i.hole && valid_q;
        if (hole_q) begin
          valid_d    = next_valid_i;
          slot_d     = next_slot_i;
          time_d     = next_time_i;
          reload_d   = next_reload_i;
          periodic_d = next_periodic_i;
        end
      end
      CELL_POP: begin
        valid_d    = next_valid_i;
        slot_d     = next_slot_i;
        time_d     = next_time_i;
        reload_d   = next_reload_i;
        periodic_d = next_periodic_i;
      end
      CELL_SUB: begin
        if (valid_q) begin
          time_d = time_q - sub_i;
        end
      end
      CELL_INSERT: begin
        if (shift && prev_link_i.shift) begin
          valid_d    = prev_valid_i;
          slot_d     = prev_slot_i;
          time_d     = prev_time_i;
          reload_d   = prev_reload_i;
          periodic_d = prev_periodic_i;
        end else if (shift) begin
          valid_d    = 1'b1;
          slot_d     = key_slot_i;
          time_d     = key_time_i;
          reload_d   = key_reload_i;
          periodic_d = key_periodic_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hole_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hole_q  <= hole_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    time_q     <= time_d;
    reload_q   <= reload_d;
    periodic_q <= periodic_d;
  end

  assign valid_o    = valid_q;
  assign slot_o     = slot_q;
  assign time_o     = time_q;
  assign reload_o   = reload_q;
  assign periodic_o = periodic_q;

endmodule

// ----- src/dltq_fire_buf.sv -----
// Ordered buffer of the timers expired by one tick, read at its head and rotated.
module dltq_fire_buf #(
  parameter int NUM_TIMERS = 16,
  parameter int SLOT_W     = 4,
  parameter int TIME_W     = 24,
  parameter int CNT_W      = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dltq_pkg::fb_op_e   op_i,
  input  logic [SLOT_W-1:0]  push_slot_i,
  input  logic [TIME_W-1:0]  push_reload_i,
  input  logic               push_periodic_i,
  output logic [SLOT_W-1:0]  head_slot_o,
  output logic [TIME_W-1:0]  head_reload_o,
  output logic               head_periodic_o,
  output logic [CNT_W-1:0]   count_o
);
  import dltq_pkg::*;

  logic [SLOT_W-1:0] slot_q     [NUM_TIMERS];
  logic [TIME_W-1:0] reload_q   [NUM_TIMERS];
  logic              periodic_q [NUM_TIMERS];
  logic [CNT_W-1:0]  count_q, count_d;
  logic              full;

  assign full = (count_q == CNT_W'(NUM_TIMERS));

  always_comb begin
    count_d = count_q;
    case (op_i)
      FB_CLEAR: count_d = '0;
      FB_PUSH:  if (!full) count_d = count_q + 1'b1;
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Rotation turns the filled entries as a ring; the entry at the fill edge takes the head.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_ent
    if (i < NUM_TIMERS - 1) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (op_i == FB_PUSH && count_q == CNT_W'(i)) begin
          slot_q[i]     <= push_slot_i;
          reload_q[i]   <= push_reload_i;
          periodic_q[i] <= push_periodic_i;
        end else if (op_i == FB_ROTATE) begin
          if (count_q == CNT_W'(i + 1)) begin
            slot_q[i]     <= slot_q[0];
            reload_q[i]   <= reload_q[0];
            periodic_q[i] <= periodic_q[0];
          end else begin
            slot_q[i]     <= slot_q[i+1];
            reload_q[i]   <= reload_q[i+1];
            periodic_q[i] <= periodic_q[i+1];
          end
        end
      end
    end else begin : g_end
      always_ff @(posedge clk_i) begin
        if (op_i == FB_PUSH && count_q == CNT_W'(i)) begin
          slot_q[i]     <= push_slot_i;
          reload_q[i]   <= push_reload_i;
          periodic_q[i] <= push_periodic_i;
        end else if (op_i == FB_ROTATE) begin
          slot_q[i]     <= slot_q[0];
          reload_q[i]   <= reload_q[0];
          periodic_q[i] <= periodic_q[0];
        end
      end
    end
  end

  assign head_slot_o     = slot_q[0];
  assign head_reload_o   = reload_q[0];
  assign head_periodic_o = periodic_q[0];
  assign count_o         = count_q;

endmodule

// ----- src/delta_list_timer_queue.sv -----
// Delta-list timer queue: a row of sorted timer cells with a sequencer and a fired-timer buffer.
// Add: mark the slot's old entry, compact out the hole, insert in order, then the result.
// Remove: mark and compact as for add, then the result.
// Tick with F expiries: pop, subtract, re-arm, then max(1, min(F, 16)) result transactions.
// The walk moves one entry per cycle through the cell row and the fired buffer.
// Reset empties the queue at once; no input is taken while results are pending.
module delta_list_timer_queue #(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_BITS  = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: slot, period_ms, periodic, elapsed_ms, zero fill.
  input  logic [dltq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0: mode.
  input  logic [dltq_pkg::MODE_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0: fired_slot, first_timeout, zero fill.
  output logic [dltq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // Fields from bit 0: fired.
  output logic [0:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);
  import dltq_pkg::*;

  localparam int SLOT_W = $clog2(NUM_TIMERS);
  localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
  localparam int WIDE_W = (TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W;
  localparam int PER_W  = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;
  localparam int PAD_W  = OUT_TDATA_W - OUT_USED_W;

  state_e               state_q, state_d;
  mode_e                mode_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [TIME_BITS-1:0] time_q;
  logic                 periodic_q;
  logic [WIDE_W-1:0]    elapsed_q;
  logic [CNT_W-1:0]     rearm_q, rearm_d;
  logic [RES_W-1:0]     emit_q, emit_d;

  logic                 in_fire;
  logic                 out_fire;
  logic                 slot_ok;
  logic [SLOT_IN_W-1:0] in_slot;
  logic [PERIOD_W-1:0]  in_period;
  logic [PER_W-1:0]     period_wide;
  logic [PER_W-1:0]     time_max_wide;
  logic [PER_W-1:0]     period_sat;
  mode_e                in_mode;

  cell_op_e             cell_op;
  fb_op_e               fb_op;
  logic [SLOT_W-1:0]    key_slot;
  logic [TIME_BITS-1:0] key_time;
  logic                 key_periodic;

  logic                 cv_valid    [NUM_TIMERS+2];
  logic [SLOT_W-1:0]    cv_slot     [NUM_TIMERS+2];
  logic [TIME_BITS-1:0] cv_time     [NUM_TIMERS+2];
  logic [TIME_BITS-1:0] cv_reload   [NUM_TIMERS+2];
  logic                 cv_periodic [NUM_TIMERS+2];
  cell_link_t           lnk         [NUM_TIMERS+1];
  logic [NUM_TIMERS-1:0] hole_vec;
  logic                 any_hole;

  logic [SLOT_W-1:0]    fb_slot;
  logic [TIME_BITS-1:0] fb_reload;
  logic                 fb_periodic;
  logic [CNT_W-1:0]     fb_count;

  logic [WIDE_W-1:0]    head_wide;
  logic                 head_expires;
  logic [PER_W-1:0]     head_ft_wide;
  logic [FT_W-1:0]      first_timeout;
  logic [RES_W-1:0]     n_res;
  logic                 res_fired;
  logic                 res_last;
  logic [SLOT_IN_W-1:0] res_slot;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  assign in_mode       = mode_e'(s_axis_tuser);
  assign in_slot       = s_axis_tdata[IN_SLOT_LSB +: SLOT_IN_W];
  assign in_period     = s_axis_tdata[IN_PERIOD_LSB +: PERIOD_W];
  assign slot_ok       = (int'(in_slot) < NUM_TIMERS);
  assign period_wide   = PER_W'(in_period);
  assign time_max_wide = PER_W'({TIME_BITS{1'b1}});
  assign period_sat    = (period_wide > time_max_wide) ? time_max_wide : period_wide;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q     <= in_mode;
      slot_q     <= SLOT_W'(in_slot);
      time_q     <= period_sat[TIME_BITS-1:0];
      periodic_q <= s_axis_tdata[IN_PERIODIC_LSB];
      elapsed_q  <= WIDE_W'(s_axis_tdata[IN_ELAPSED_LSB +: ELAPSED_W]);
    end
  end

  // Cell row with constant boundary entries at both ends.
  assign cv_valid[0]               = 1'b0;
  assign cv_slot[0]                = '0;
  assign cv_time[0]                = '0;
  assign cv_reload[0]              = '0;
  assign cv_periodic[0]            = 1'b0;
  assign cv_valid[NUM_TIMERS+1]    = 1'b0;
  assign cv_slot[NUM_TIMERS+1]     = '0;
  assign cv_time[NUM_TIMERS+1]     = '0;
  assign cv_reload[NUM_TIMERS+1]   = '0;
  assign cv_periodic[NUM_TIMERS+1] = 1'b0;
  assign lnk[0]                    = '{lt: 1'b1, shift: 1'b0, hole: 1'b0};

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    dltq_cell #(
      .SLOT_W(SLOT_W),
      .TIME_W(TIME_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .op_i           (cell_op),
      .prev_link_i    (lnk[i]),
      .link_o         (lnk[i+1]),
      .prev_valid_i   (cv_valid[i]),
      .prev_slot_i    (cv_slot[i]),
      .prev_time_i    (cv_time[i]),
      .prev_reload_i  (cv_reload[i]),
      .prev_periodic_i(cv_periodic[i]),
      .next_valid_i   (cv_valid[i+2]),
      .next_slot_i    (cv_slot[i+2]),
      .next_time_i    (cv_time[i+2]),
      .next_reload_i  (cv_reload[i+2]),
      .next_periodic_i(cv_periodic[i+2]),
      .key_slot_i     (key_slot),
      .key_time_i     (key_time),
      .key_reload_i   (key_time),
      .key_periodic_i (key_periodic),
      .sub_i          (elapsed_q[TIME_BITS-1:0]),
      .valid_o        (cv_valid[i+1]),
      .slot_o         (cv_slot[i+1]),
      .time_o         (cv_time[i+1]),
      .reload_o       (cv_reload[i+1]),
      .periodic_o     (cv_periodic[i+1])
    );
    assign hole_vec[i] = lnk[i+1].hole;
  end

  assign any_hole = |hole_vec;

  dltq_fire_buf #(
    .NUM_TIMERS(NUM_TIMERS),
    .SLOT_W    (SLOT_W),
    .TIME_W    (TIME_BITS),
    .CNT_W     (CNT_W)
  ) u_fire_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (fb_op),
    .push_slot_i    (cv_slot[1]),
    .push_reload_i  (cv_reload[1]),
    .push_periodic_i(cv_periodic[1]),
    .head_slot_o    (fb_slot),
    .head_reload_o  (fb_reload),
    .head_periodic_o(fb_periodic),
    .count_o        (fb_count)
  );

  assign head_wide    = WIDE_W'(cv_time[1]);
  assign head_expires = cv_valid[1] && (head_wide <= elapsed_q);

  // Next state and walk counters.
  always_comb begin
    state_d = state_q;
    rearm_d = rearm_q;
    emit_d  = emit_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          emit_d = '0;
          unique case (in_mode)
            MODE_ADD, MODE_REMOVE: state_d = slot_ok ? ST_MARK : ST_EMIT;
            MODE_TICK:             state_d = ST_POP;
            default:               state_d = ST_EMIT;
          endcase
        end
      end
      ST_MARK: begin
        state_d = ST_COMPACT;
      end
      ST_COMPACT: begin
        if (!any_hole) begin
          state_d = (mode_q == MODE_ADD) ? ST_INSERT : ST_EMIT;
        end
      end
      ST_INSERT: begin
        state_d = ST_EMIT;
      end
      ST_POP: begin
        if (!head_expires) begin
          state_d = ST_REARM;
          rearm_d = '0;
        end
      end
      ST_REARM: begin
        if (rearm_q == fb_count) begin
          state_d = ST_EMIT;
        end else begin
          rearm_d = rearm_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          emit_d = emit_q + 1'b1;
          if (res_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    cell_op       = CELL_HOLD;
    fb_op         = FB_HOLD;
    key_slot      = slot_q;
    key_time      = time_q;
    key_periodic  = periodic_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_fire) begin
          fb_op = FB_CLEAR;
        end
      end
      ST_MARK:    cell_op = CELL_MARK;
      ST_COMPACT: cell_op = CELL_COMPACT;
      ST_INSERT:  cell_op = CELL_INSERT;
      ST_POP: begin
        if (head_expires) begin
          cell_op = CELL_POP;
          fb_op   = FB_PUSH;
        end else begin
          cell_op = CELL_SUB;
        end
      end
      ST_REARM: begin
        key_slot     = fb_slot;
        key_time     = fb_reload;
        key_periodic = 1'b1;
        if (rearm_q != fb_count) begin
          fb_op = FB_ROTATE;
          if (fb_periodic) begin
            cell_op = CELL_INSERT;
          end
        end
      end
      ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        if (out_fire) begin
          fb_op = FB_ROTATE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rearm_q <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      rearm_q <= rearm_d;
      emit_q  <= emit_d;
    end
  end

  // Result fields, stable while the chain holds during the emit phase.
  assign head_ft_wide  = PER_W'(cv_time[1]);
  assign first_timeout = cv_valid[1] ? head_ft_wide[FT_W-1:0] : '0;
  assign n_res         = (int'(fb_count) > RESULT_CAP) ? RES_W'(RESULT_CAP) : RES_W'(fb_count);
  assign res_fired     = (n_res != '0);
  assign res_last      = !res_fired || ((emit_q + 1'b1) == n_res);
  assign res_slot      = res_fired ? SLOT_IN_W'(fb_slot) : '0;

  assign m_axis_tdata = {{PAD_W{1'b0}}, first_timeout, res_slot};
  assign m_axis_tuser = res_fired;
  assign m_axis_tlast = res_last;

endmodule

// ----- src/dltq_checker.sv -----
// Port-level checks for the delta-list timer queue and their binding to the top level.
module dltq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [dltq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                       m_axis_tuser,
  input logic                             m_axis_tlast
);
  import dltq_pkg::*;

  logic [SLOT_IN_W-1:0] out_slot;

  assign out_slot = m_axis_tdata[SLOT_IN_W-1:0];

  a_no_accept_while_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready
  ) else $error("input ready while a result is pending");

  a_ready_after_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready
  ) else $error("block not ready after the final result transaction");

  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready
  ) else $error("second input transaction taken before results");

  a_no_fire_is_single : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && out_slot == '0)
  ) else $error("result without expiry is not a single cleared transaction");

  a_result_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
  ) else $error("stalled result changed");

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (.*);
